>>> rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and constants of the parallel port strobe handler
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int KEY_CHARS   = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [7:0] CHUNK_SIZE_RESET = 8'd196;
   localparam logic [7:0] PRINT_LOW        = 8'd32;

   typedef enum logic [1:0] {
      OP_STROBE = 2'd0,
      OP_BEGIN  = 2'd1,
      OP_END    = 2'd2,
      OP_POLL   = 2'd3
   } op_type;

   typedef enum logic {
      REG_CHUNK_SIZE = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic key_ready;
      logic buffer_filled;
      logic all_sent;
      logic got_strobe;
   } flags_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  port_byte;
      logic [7:0]  next_byte;
      logic [15:0] send_length;
      logic        busy_line;
   } item_type;

   typedef struct packed {
      logic [7:0]  drive_byte;
      logic        drive_enable;
      logic        ack_pulse;
      logic        byte_taken;
      logic        got_strobe;
      logic        all_sent;
      logic        buffer_filled;
      logic        is_busy;
      logic        key_ready;
      logic [31:0] key_word;
   } result_type;

endpackage

>>> rtl/core/parallel_port_strobe_handler_core.sv
// ----------------------------------------------------------------------------
// parallel_port_strobe_handler_core
// peripheral side of a parallel port strobe handshake, receive and send modes
// ----------------------------------------------------------------------------
// The block takes one request per clock while rsp_tready does not hold the result
// register, and gives one response for each. A request sits in the input register,
// the engine updates the handshake state and forms the response in the same cycle
// it moves into the result register, so the next request already sees the updated
// state. chunk_size is to be written through the csr port at byte address 0 only
// while no request is in flight; the block itself does not enforce this.
module parallel_port_strobe_handler_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pps_pkg::REQ_TDATA_W-1:0]  req_tdata,  // port_byte, next_byte, send_length, busy_line
   input  logic [1:0]                       req_tuser,  // op
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // drive_byte, drive_enable, ack_pulse, byte_taken, got_strobe, all_sent,
   // buffer_filled, is_busy, key_ready, key_word
   output logic [pps_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pps_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   logic                 chunk_size_ff;
   logic [7:0]           chunk_ff;
   logic [7:0]           chunk_in;
   logic                 csr_hit;
   logic                 item_valid;
   logic                 advance;
   logic                 fire;
   pps_pkg::item_type    item;
   pps_pkg::result_type  result;

   assign csr_pready = 1'b1;
   assign csr_hit    = pps_pkg::reg_index_type'(csr_paddr[2]) == pps_pkg::REG_CHUNK_SIZE;

   always_comb begin
      chunk_in = chunk_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         chunk_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff      <= pps_pkg::CHUNK_SIZE_RESET;
         chunk_size_ff <= 1'b0;
      end else begin
         chunk_ff      <= chunk_in;
         chunk_size_ff <= chunk_in != chunk_ff;
      end
   end

   assign csr_prdata = csr_hit ? {24'd0, chunk_ff} : '0;

   assign fire = item_valid && advance;

   pps_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   pps_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .chunk_size (chunk_ff),
      .fire       (fire),
      .item       (item),
      .result     (result)
   );

   pps_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (result),
      .can_load   (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // poll responses carry no ack and consume no byte
   a_poll_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[11] || rsp_tdata[12] || rsp_tdata[13] || rsp_tdata[15])
      |-> !rsp_tdata[9] && !rsp_tdata[10])
      else $error("flags reported together with ack or byte taken");

   // all-sent and buffer-filled only come from a send strobe
   a_flags_need_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[12] || rsp_tdata[13]) |-> rsp_tdata[11])
      else $error("send flags reported without got strobe");

   // a held request is not dropped from the input register
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid && !advance |=> item_valid)
      else $error("stalled request lost");

   // chunk size changes only by a csr write
   a_chunk_write: assert property (@(posedge clock) disable iff (reset)
      chunk_size_ff |-> $past(csr_psel && csr_penable && csr_pwrite && csr_hit))
      else $error("chunk size changed without a write");

endmodule

>>> rtl/core/pps_in_stage.sv
// ----------------------------------------------------------------------------
// pps_in_stage
// request register in front of the strobe engine
// ----------------------------------------------------------------------------
module pps_in_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pps_pkg::REQ_TDATA_W-1:0]  req_tdata,  // port_byte, next_byte, send_length, busy_line
   input  logic [1:0]                       req_tuser,  // op
   input  logic                             advance,
   output logic                             item_valid,
   output pps_pkg::item_type                item
);

   logic               valid_ff;
   logic               valid_in;
   pps_pkg::item_type  item_ff;
   pps_pkg::item_type  item_in;
   logic               take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      item_in             = item_ff;
      valid_in            = valid_ff;
      if (take) begin
         item_in.op          = pps_pkg::op_type'(req_tuser);
         item_in.port_byte   = req_tdata[7:0];
         item_in.next_byte   = req_tdata[15:8];
         item_in.send_length = req_tdata[31:16];
         item_in.busy_line   = req_tdata[32];
         valid_in            = 1'b1;
      end else if (advance) begin
         valid_in            = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/core/pps_engine.sv
// ----------------------------------------------------------------------------
// pps_engine
// handshake state and its update for each request
// ----------------------------------------------------------------------------
module pps_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           chunk_size,
   input  logic                 fire,
   input  pps_pkg::item_type    item,
   output pps_pkg::result_type  result
);

   logic                send_mode_ff,      send_mode_in;
   logic [7:0]          strobe_counter_ff, strobe_counter_in;
   logic [31:0]         key_shift_ff,      key_shift_in;
   logic [15:0]         bytes_left_ff,     bytes_left_in;
   logic [7:0]          port_out_ff,       port_out_in;
   pps_pkg::flags_type  flags_ff,          flags_in;

   logic [7:0]  count_inc;
   logic        printable;
   logic        ack;
   logic        taken;

   assign count_inc = strobe_counter_ff + 8'd1;
   assign printable = (item.port_byte >= pps_pkg::PRINT_LOW) && !item.port_byte[7];

   always_comb begin
      send_mode_in      = send_mode_ff;
      strobe_counter_in = strobe_counter_ff;
      key_shift_in      = key_shift_ff;
      bytes_left_in     = bytes_left_ff;
      port_out_in       = port_out_ff;
      flags_in          = flags_ff;
      ack               = 1'b0;
      taken             = 1'b0;
      result            = '0;

      case (item.op)
         pps_pkg::OP_STROBE: begin
            ack = 1'b1;
            if (!send_mode_ff) begin
               if (printable) begin
                  key_shift_in      = {key_shift_ff[23:0], item.port_byte};
                  strobe_counter_in = count_inc;
                  if (count_inc == 8'(pps_pkg::KEY_CHARS)) begin
                     flags_in.key_ready = 1'b1;
                     strobe_counter_in  = '0;
                  end
               end
            end else begin
               flags_in            = '0;
               flags_in.got_strobe = 1'b1;
               if (bytes_left_ff == '0) begin
                  port_out_in       = '0;
                  flags_in.all_sent = 1'b1;
               end else begin
                  port_out_in   = item.next_byte;
                  bytes_left_in = bytes_left_ff - 16'd1;
                  taken         = 1'b1;
               end
               strobe_counter_in = count_inc;
               if (count_inc == chunk_size) begin
                  strobe_counter_in = '0;
                  if (bytes_left_in == '0) begin
                     flags_in.buffer_filled = 1'b1;
                     ack                    = 1'b0;
                  end
               end
            end
         end
         pps_pkg::OP_BEGIN: begin
            bytes_left_in     = (item.send_length == '0) ? '0 : item.send_length - 16'd1;
            port_out_in       = item.next_byte;
            taken             = 1'b1;
            send_mode_in      = 1'b1;
            flags_in          = '0;
            strobe_counter_in = '0;
         end
         pps_pkg::OP_END: begin
            send_mode_in      = 1'b0;
            flags_in          = '0;
            strobe_counter_in = '0;
         end
         default: begin
            flags_in             = '0;
            result.got_strobe    = flags_ff.got_strobe;
            result.all_sent      = flags_ff.all_sent;
            result.buffer_filled = flags_ff.buffer_filled;
            result.key_ready     = flags_ff.key_ready;
            result.is_busy       = item.busy_line;
            result.key_word      = key_shift_ff;
         end
      endcase

      result.drive_byte   = send_mode_in ? port_out_in : '0;
      result.drive_enable = send_mode_in;
      result.ack_pulse    = ack;
      result.byte_taken   = taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         send_mode_ff      <= 1'b0;
         strobe_counter_ff <= '0;
         key_shift_ff      <= '0;
         bytes_left_ff     <= '0;
         port_out_ff       <= '0;
         flags_ff          <= '0;
      end else if (fire) begin
         send_mode_ff      <= send_mode_in;
         strobe_counter_ff <= strobe_counter_in;
         key_shift_ff      <= key_shift_in;
         bytes_left_ff     <= bytes_left_in;
         port_out_ff       <= port_out_in;
         flags_ff          <= flags_in;
      end
   end

endmodule

>>> rtl/core/pps_out_stage.sv
// ----------------------------------------------------------------------------
// pps_out_stage
// result register toward the response stream
// ----------------------------------------------------------------------------
module pps_out_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  pps_pkg::result_type              result,
   output logic                             can_load,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // drive_byte, drive_enable, ack_pulse, byte_taken, got_strobe, all_sent,
   // buffer_filled, is_busy, key_ready, key_word
   output logic [pps_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   logic                 valid_ff;
   logic                 valid_in;
   pps_pkg::result_type  result_ff;
   pps_pkg::result_type  result_in;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (rsp_tready) begin
         valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {result_ff.key_word,
                        result_ff.key_ready,
                        result_ff.is_busy,
                        result_ff.buffer_filled,
                        result_ff.all_sent,
                        result_ff.got_strobe,
                        result_ff.byte_taken,
                        result_ff.ack_pulse,
                        result_ff.drive_enable,
                        result_ff.drive_byte};

endmodule
